[sv/lgb_pkg.sv]
// Shared constants and the elaboration-time threshold table for the gamma byte encoder.
package lgb_pkg;

  localparam int unsigned FloatW = 32;
  localparam int unsigned MagW   = 31;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned NumCodes = 256;

  // Bit pattern of 1.0 in single precision; everything at or above it is full scale.
  localparam logic [FloatW-1:0] FloatOne = 32'h3F80_0000;

  // Wide enough for (2k-1)^11 shifted by five times the largest scale (149).
  localparam int unsigned BigW = 880;

  typedef logic [MagW-1:0] thr_tab_t [NumCodes];

  // True when the positive float below one reaches ((2k-1)/510)^2.2, tested exactly
  // as m^5 * 510^11 >= (2k-1)^11 * 2^(5s).
  function automatic logic reaches_fn(logic [FloatW-1:0] bits, int unsigned k);
    logic [BigW-1:0] lhs;
    logic [BigW-1:0] rhs;
    logic [BigW-1:0] mul_m;
    logic [BigW-1:0] mul_k;
    logic [BigW-1:0] mul_c;
    int unsigned     scale;
    int unsigned     i;
    lhs   = BigW'(1);
    rhs   = BigW'(1);
    mul_c = BigW'(510);
    mul_k = BigW'(2 * k - 1);
    if (bits[30:23] == 8'd0) begin
      mul_m = BigW'(bits[22:0]);
      scale = 149;
    end else begin
      mul_m = BigW'({1'b1, bits[22:0]});
      scale = 150 - int'(bits[30:23]);
    end
    for (i = 0; i < 5; i++) begin
      lhs = lhs * mul_m;
    end
    for (i = 0; i < 11; i++) begin
      lhs = lhs * mul_c;
      rhs = rhs * mul_k;
    end
    rhs = rhs << (5 * scale);
    return (lhs >= rhs);
  endfunction

  // Smallest positive pattern below one that reaches code k, or the pattern of one.
  function automatic logic [MagW-1:0] find_thr(int unsigned k);
    logic [FloatW-1:0] lo;
    logic [FloatW-1:0] hi;
    logic [FloatW-1:0] mid;
    lo = FloatW'(1);
    hi = FloatOne;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (reaches_fn(mid, k)) begin
        hi = mid;
      end else begin
        lo = mid + FloatW'(1);
      end
    end
    return lo[MagW-1:0];
  endfunction

  function automatic thr_tab_t build_thr_tab();
    thr_tab_t    tab;
    int unsigned k;
    tab[0] = '0;
    for (k = 1; k < NumCodes; k++) begin
      tab[k] = find_thr(k);
    end
    return tab;
  endfunction

  // Entry k is the lowest magnitude pattern that encodes to at least k.
  localparam thr_tab_t ThrTab = build_thr_tab();

endpackage

[sv/lgb_chan_enc.sv]
// One channel of the encoder: float bit pattern to gamma 2.2 display byte.
module lgb_chan_enc (
  input  logic [lgb_pkg::FloatW-1:0] linear,
  output logic [lgb_pkg::CodeW-1:0]  code
);

  logic [lgb_pkg::NumCodes-1:0] ge;
  logic [lgb_pkg::CodeW-1:0]    acc [lgb_pkg::CodeW+1];
  logic [lgb_pkg::CodeW-1:0]    trial [lgb_pkg::CodeW];

  // All thresholds are compared at once; the result is a thermometer code.
  always_comb begin
    for (int unsigned k = 0; k < lgb_pkg::NumCodes; k++) begin
      ge[k] = (linear[lgb_pkg::MagW-1:0] >= lgb_pkg::ThrTab[k]);
    end
  end

  // The thermometer is turned into a count by a bitwise search, one bit at a time.
  always_comb begin
    acc[0] = '0;
    for (int unsigned b = 0; b < lgb_pkg::CodeW; b++) begin
      trial[b]  = acc[b] | (lgb_pkg::CodeW'(1) << (lgb_pkg::CodeW - 1 - b));
      acc[b+1]  = ge[trial[b]] ? trial[b] : acc[b];
    end
  end

  // Anything with the sign bit set, NaN and zero included, is black.
  assign code = linear[lgb_pkg::FloatW-1] ? '0 : acc[lgb_pkg::CodeW];

endmodule

[sv/linear_rgb_float_to_gamma_bytes.sv]
// Top level of the linear float RGB to gamma 2.2 byte encoder.
//
// Usage: one pixel word arrives on the in_ channel as three single-precision
// bit patterns and one word leaves on the out_ channel as three bytes, each
// round(clamp(x,0,1)^(1/2.2)*255). Both channels use valid and stall; a word
// moves at a clock edge where valid is high and stall is low.
// Negative inputs, negative zero and negative NaN give 0; one and above,
// positive infinity and positive NaN give 255; ties round up.
// The path is an input register, a bank of parallel threshold compares with a
// bitwise search, and the output register. An accepted word passes from the
// input register to the output register, where out_valid rises with it, once
// that register is free. A word is taken every cycle while in_stall is low.
// When the receiver stalls, the output word holds and one further word may be
// taken into the input register; in_stall rises only while both registers are
// full and out_stall is high.
// Reset clears both valid flags; the channels are usable in the next cycle.
module linear_rgb_float_to_gamma_bytes (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lgb_pkg::FloatW-1:0]  in_red_linear,
  input  logic [lgb_pkg::FloatW-1:0]  in_green_linear,
  input  logic [lgb_pkg::FloatW-1:0]  in_blue_linear,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lgb_pkg::CodeW-1:0]   out_red_code,
  output logic [lgb_pkg::CodeW-1:0]   out_green_code,
  output logic [lgb_pkg::CodeW-1:0]   out_blue_code
);

  logic                       s1_valid_r;
  logic [lgb_pkg::FloatW-1:0] s1_red_r;
  logic [lgb_pkg::FloatW-1:0] s1_green_r;
  logic [lgb_pkg::FloatW-1:0] s1_blue_r;
  logic                       out_valid_r;
  logic [lgb_pkg::CodeW-1:0]  red_code_r;
  logic [lgb_pkg::CodeW-1:0]  green_code_r;
  logic [lgb_pkg::CodeW-1:0]  blue_code_r;
  logic [lgb_pkg::CodeW-1:0]  red_code_nxt;
  logic [lgb_pkg::CodeW-1:0]  green_code_nxt;
  logic [lgb_pkg::CodeW-1:0]  blue_code_nxt;
  logic                       out_adv;
  logic                       s1_adv;
  logic                       in_take;

  assign out_adv = !out_valid_r || !out_stall;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;
  assign in_take  = in_valid && s1_adv;

  lgb_chan_enc u_red (
    .linear (s1_red_r),
    .code   (red_code_nxt)
  );

  lgb_chan_enc u_green (
    .linear (s1_green_r),
    .code   (green_code_nxt)
  );

  lgb_chan_enc u_blue (
    .linear (s1_blue_r),
    .code   (blue_code_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_red_r   <= in_red_linear;
      s1_green_r <= in_green_linear;
      s1_blue_r  <= in_blue_linear;
    end
    if (out_adv && s1_valid_r) begin
      red_code_r   <= red_code_nxt;
      green_code_r <= green_code_nxt;
      blue_code_r  <= blue_code_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_code   = red_code_r;
  assign out_green_code = green_code_r;
  assign out_blue_code  = blue_code_r;

endmodule

[sv/lgb_checker.sv]
// Port-level assertions for the gamma byte encoder, bound to the top level.
module lgb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [lgb_pkg::FloatW-1:0] in_red_linear,
  input logic [lgb_pkg::FloatW-1:0] in_green_linear,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [lgb_pkg::CodeW-1:0]  out_red_code,
  input logic [lgb_pkg::CodeW-1:0]  out_green_code
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // The block only pushes back when the output word is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("in_stall raised while the output is free");

  // A negative red value that goes straight through comes out black.
  a_neg_black: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_red_linear[lgb_pkg::FloatW-1])
      ##1 (!out_valid || !out_stall)
      |=> (out_valid && (out_red_code == '0)))
    else $error("negative input did not encode to zero");

  // A green value of one or more that goes straight through comes out full.
  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_green_linear[lgb_pkg::FloatW-1]
      && (in_green_linear >= lgb_pkg::FloatOne))
      ##1 (!out_valid || !out_stall)
      |=> (out_valid && (out_green_code == '1)))
    else $error("input of one or more did not encode to full scale");

  // A held output word keeps its red code.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_red_code)))
    else $error("stalled output word changed");

endmodule

bind linear_rgb_float_to_gamma_bytes lgb_checker u_lgb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_red_linear   (in_red_linear),
  .in_green_linear (in_green_linear),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_red_code    (out_red_code),
  .out_green_code  (out_green_code)
);
